// ===== hw/rtl/att_pkg.sv =====
// Shared types, widths, angle constants, the arctangent table and the square root step of the tilt angle pipeline.
package att_pkg;

	localparam int SqW    = 32;  // sum of two squares
	localparam int RootW  = 32;  // floor(sqrt(sum * 2^32))
	localparam int RemW   = 36;  // square root partial remainder
	localparam int NumW   = 17;  // numerator, -32768..32768
	localparam int VecW   = 36;  // CORDIC x and y
	localparam int AccW   = 25;  // CORDIC angle accumulator, Q16 degrees
	localparam int AngW   = 26;  // angle after the fold
	localparam int AtanEntries = 24;

	localparam logic signed [AngW-1:0] Deg90Q16  = AngW'(5898240);
	localparam logic signed [AngW-1:0] Deg180Q16 = AngW'(11796480);
	localparam logic signed [AngW:0]   RoundQ16  = (AngW+1)'(2048);

	typedef struct packed {
		logic signed [NumW-1:0] num_p;   // pitch numerator, y
		logic signed [NumW-1:0] num_r;   // roll numerator, -x
		logic                   z_neg;
	} side_t;

	typedef struct packed {
		logic [RemW-1:0]  rem;
		logic [RootW-1:0] root;
	} sqrt_t;

	// atan(2^-i) in degrees, Q16, rounded to nearest
	function automatic logic [22:0] atan_q16(input logic [4:0] idx);
		logic [22:0] v;
		unique case (idx)
			5'd0:  v = 23'd2949120;
			5'd1:  v = 23'd1740967;
			5'd2:  v = 23'd919879;
			5'd3:  v = 23'd466945;
			5'd4:  v = 23'd234379;
			5'd5:  v = 23'd117304;
			5'd6:  v = 23'd58666;
			5'd7:  v = 23'd29335;
			5'd8:  v = 23'd14668;
			5'd9:  v = 23'd7334;
			5'd10: v = 23'd3667;
			5'd11: v = 23'd1833;
			5'd12: v = 23'd917;
			5'd13: v = 23'd458;
			5'd14: v = 23'd229;
			5'd15: v = 23'd115;
			5'd16: v = 23'd57;
			5'd17: v = 23'd29;
			5'd18: v = 23'd14;
			5'd19: v = 23'd7;
			5'd20: v = 23'd4;
			5'd21: v = 23'd2;
			5'd22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return v;
	endfunction

	// one digit of a restoring square root: bring down two bits, try, keep
	function automatic sqrt_t sqrt_step(input sqrt_t cur, input logic [1:0] bits);
		sqrt_t          nxt;
		logic [RemW-1:0] r;
		logic [RemW-1:0] trial;
		r     = {cur.rem[RemW-3:0], bits};
		trial = {2'b00, cur.root, 2'b01};
		if (r >= trial) begin
			nxt.rem  = r - trial;
			nxt.root = {cur.root[RootW-2:0], 1'b1};
		end else begin
			nxt.rem  = r;
			nxt.root = {cur.root[RootW-2:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

// ===== hw/rtl/accel_tilt_angles.sv =====
// Tilt angles (roll, pitch) from one three-axis accelerometer sample, fully pipelined.
//
// Usage: raise start with a sample on accel_x/y/z; busy is tied low, so a sample is
// taken in every cycle that start is high. Each sample yields exactly one result,
// shown for one cycle with done high, after two product/sum stages, 32 square root
// digit stages, one stage per CORDIC iteration (min(CORDIC_STEPS, 24) of them) and
// two output stages. The receiver cannot hold results off and results keep input
// order. Angles are in sixteenths of a degree: roll -1440..1440, pitch -1440..4320
// (folded to 180 - pitch when z is negative). An all-zero sample gives zero angles
// and undefined_angle = 1.
module accel_tilt_angles
	import att_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	output logic               done,
	output logic signed [11:0] roll_angle,
	output logic signed [13:0] pitch_angle,
	output logic               undefined_angle
);

	localparam int NStep = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;

	// every stage advances every cycle; nothing ever stalls
	assign busy = 1'b0;

	// ---- stage 1: squares ----
	logic              vld_s1;
	logic [31:0]       xx_s1, yy_s1, zz_s1;
	side_t             side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		xx_s1 <= 32'(accel_x * accel_x);
		yy_s1 <= 32'(accel_y * accel_y);
		zz_s1 <= 32'(accel_z * accel_z);
		side_s1.num_p <= NumW'(accel_y);
		side_s1.num_r <= -NumW'(accel_x);
		side_s1.z_neg <= accel_z[15];
	end

	// ---- stage 2: sums of squares ----
	logic              vld_s2;
	logic [SqW-1:0]    sqp_s2, sqr_s2;
	side_t             side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		sqp_s2  <= xx_s1 + zz_s1;
		sqr_s2  <= yy_s1 + zz_s1;
		side_s2 <= side_s1;
	end

	// ---- square root: one result bit per stage, both lanes side by side ----
	logic           vld_sq  [RootW];
	sqrt_t          rtp_sq  [RootW];
	sqrt_t          rtr_sq  [RootW];
	logic [SqW-1:0] sqp_sq  [RootW];
	logic [SqW-1:0] sqr_sq  [RootW];
	side_t          side_sq [RootW];

	for (genvar k = 0; k < RootW; k++) begin : g_sqrt
		localparam int B = RootW - 1 - k;  // bit pair of sum * 2^32
		logic           vld_in;
		sqrt_t          rtp_in, rtr_in;
		logic [SqW-1:0] sqp_in, sqr_in;
		side_t          side_in;
		logic [1:0]     bits_p, bits_r;

		if (k == 0) begin : g_first
			assign vld_in  = vld_s2;
			assign rtp_in  = '0;
			assign rtr_in  = '0;
			assign sqp_in  = sqp_s2;
			assign sqr_in  = sqr_s2;
			assign side_in = side_s2;
		end else begin : g_next
			assign vld_in  = vld_sq[k-1];
			assign rtp_in  = rtp_sq[k-1];
			assign rtr_in  = rtr_sq[k-1];
			assign sqp_in  = sqp_sq[k-1];
			assign sqr_in  = sqr_sq[k-1];
			assign side_in = side_sq[k-1];
		end

		// the low 32 bits of sum * 2^32 are zero
		if (B >= 16) begin : g_hi
			assign bits_p = sqp_in[2*(B-16) +: 2];
			assign bits_r = sqr_in[2*(B-16) +: 2];
		end else begin : g_lo
			assign bits_p = 2'b00;
			assign bits_r = 2'b00;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_sq[k] <= 1'b0;
			else vld_sq[k] <= vld_in;
		end

		always_ff @(posedge clk) begin
			rtp_sq[k]  <= sqrt_step(rtp_in, bits_p);
			rtr_sq[k]  <= sqrt_step(rtr_in, bits_r);
			sqp_sq[k]  <= sqp_in;
			sqr_sq[k]  <= sqr_in;
			side_sq[k] <= side_in;
		end
	end

	// ---- vectoring CORDIC: one iteration per stage ----
	logic                   vld_cd  [NStep];
	logic signed [VecW-1:0] xp_cd   [NStep];
	logic signed [VecW-1:0] yp_cd   [NStep];
	logic signed [AccW-1:0] ap_cd   [NStep];
	logic signed [VecW-1:0] xr_cd   [NStep];
	logic signed [VecW-1:0] yr_cd   [NStep];
	logic signed [AccW-1:0] ar_cd   [NStep];
	logic                   zp_cd   [NStep];  // pitch denominator is zero
	logic                   zr_cd   [NStep];
	side_t                  side_cd [NStep];

	for (genvar i = 0; i < NStep; i++) begin : g_cordic
		logic                   vld_in, zp_in, zr_in;
		logic signed [VecW-1:0] xp_in, yp_in, xr_in, yr_in;
		logic signed [AccW-1:0] ap_in, ar_in;
		side_t                  side_in;
		logic signed [AccW-1:0] atan_v;

		if (i == 0) begin : g_first
			assign vld_in  = vld_sq[RootW-1];
			assign xp_in   = VecW'(rtp_sq[RootW-1].root);
			assign xr_in   = VecW'(rtr_sq[RootW-1].root);
			assign yp_in   = {{(VecW-NumW-16){side_sq[RootW-1].num_p[NumW-1]}},
				side_sq[RootW-1].num_p, 16'd0};
			assign yr_in   = {{(VecW-NumW-16){side_sq[RootW-1].num_r[NumW-1]}},
				side_sq[RootW-1].num_r, 16'd0};
			assign ap_in   = '0;
			assign ar_in   = '0;
			assign zp_in   = (sqp_sq[RootW-1] == '0);
			assign zr_in   = (sqr_sq[RootW-1] == '0);
			assign side_in = side_sq[RootW-1];
		end else begin : g_next
			assign vld_in  = vld_cd[i-1];
			assign xp_in   = xp_cd[i-1];
			assign yp_in   = yp_cd[i-1];
			assign ap_in   = ap_cd[i-1];
			assign xr_in   = xr_cd[i-1];
			assign yr_in   = yr_cd[i-1];
			assign ar_in   = ar_cd[i-1];
			assign zp_in   = zp_cd[i-1];
			assign zr_in   = zr_cd[i-1];
			assign side_in = side_cd[i-1];
		end

		assign atan_v = AccW'(atan_q16(5'(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_cd[i] <= 1'b0;
			else vld_cd[i] <= vld_in;
		end

		always_ff @(posedge clk) begin
			if (!yp_in[VecW-1]) begin
				xp_cd[i] <= xp_in + (yp_in >>> i);
				yp_cd[i] <= yp_in - (xp_in >>> i);
				ap_cd[i] <= ap_in + atan_v;
			end else begin
				xp_cd[i] <= xp_in - (yp_in >>> i);
				yp_cd[i] <= yp_in + (xp_in >>> i);
				ap_cd[i] <= ap_in - atan_v;
			end
			if (!yr_in[VecW-1]) begin
				xr_cd[i] <= xr_in + (yr_in >>> i);
				yr_cd[i] <= yr_in - (xr_in >>> i);
				ar_cd[i] <= ar_in + atan_v;
			end else begin
				xr_cd[i] <= xr_in - (yr_in >>> i);
				yr_cd[i] <= yr_in + (xr_in >>> i);
				ar_cd[i] <= ar_in - atan_v;
			end
			zp_cd[i]   <= zp_in;
			zr_cd[i]   <= zr_in;
			side_cd[i] <= side_in;
		end
	end

	// ---- output stage 1: zero denominators, pitch fold ----
	logic                   vld_f1, undef_f1;
	logic signed [AngW-1:0] pitch_f1, roll_f1;
	logic signed [AngW-1:0] pitch_raw, roll_raw;
	side_t                  side_end;

	assign side_end = side_cd[NStep-1];

	always_comb begin
		// zero denominator: +/-90 by numerator sign, 0 if numerator is zero too
		if (zp_cd[NStep-1]) begin
			if (side_end.num_p == '0) pitch_raw = '0;
			else if (side_end.num_p[NumW-1]) pitch_raw = -Deg90Q16;
			else pitch_raw = Deg90Q16;
		end else begin
			pitch_raw = AngW'(ap_cd[NStep-1]);
		end
		if (zr_cd[NStep-1]) begin
			if (side_end.num_r == '0) roll_raw = '0;
			else if (side_end.num_r[NumW-1]) roll_raw = -Deg90Q16;
			else roll_raw = Deg90Q16;
		end else begin
			roll_raw = AngW'(ar_cd[NStep-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_f1 <= 1'b0;
		else vld_f1 <= vld_cd[NStep-1];
	end

	always_ff @(posedge clk) begin
		pitch_f1 <= side_end.z_neg ? (Deg180Q16 - pitch_raw) : pitch_raw;
		roll_f1  <= roll_raw;
		undef_f1 <= (zp_cd[NStep-1] && (side_end.num_p == '0)) ||
			(zr_cd[NStep-1] && (side_end.num_r == '0));
	end

	// ---- output stage 2: round to 1/16 degree, saturate ----
	logic signed [AngW:0]    pitch_rnd, roll_rnd;
	logic signed [AngW-12:0] pitch_16, roll_16;

	assign pitch_rnd = (AngW+1)'(pitch_f1) + RoundQ16;
	assign roll_rnd  = (AngW+1)'(roll_f1) + RoundQ16;
	assign pitch_16  = pitch_rnd[AngW:12];
	assign roll_16   = roll_rnd[AngW:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_f1;
	end

	always_ff @(posedge clk) begin
		if (roll_16 < -(AngW-11)'(1440)) roll_angle <= -12'sd1440;
		else if (roll_16 > (AngW-11)'(1440)) roll_angle <= 12'sd1440;
		else roll_angle <= 12'(roll_16);
		if (pitch_16 < -(AngW-11)'(1440)) pitch_angle <= -14'sd1440;
		else if (pitch_16 > (AngW-11)'(4320)) pitch_angle <= 14'sd4320;
		else pitch_angle <= 14'(pitch_16);
		undefined_angle <= undef_f1;
	end

endmodule
